[hdl/ftcs_pkg.sv]
// shared types, constants and codes for the frame time clamp smoother
`default_nettype none

package ftcs_pkg;

  localparam int FTCS_WINDOW = 3;

  localparam int MIN_US_W = 20;
  localparam int MAX_MS_W = 16;
  localparam int TS_W     = 32;
  localparam int KIND_W   = 2;
  localparam int SMOOTH_W = 16;
  localparam int WAIT_W   = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_US = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_MS = 1'd1;

  localparam logic [MIN_US_W-1:0] MIN_FRAME_US_RST = 20'd16667;
  localparam logic [MAX_MS_W-1:0] MAX_FRAME_MS_RST = 16'd100;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WAIT  = 2'd2;

  localparam logic [TS_W-1:0] START_OFFSET_MS = 32'd50;

  // short frame test works on the low bits of the raw time
  localparam int RAW_LO_W = 11;
  localparam int RAW_US_W = 21;
  localparam logic [9:0] US_PER_MS = 10'd1000;

  // min_us / 1000 as multiply by ceil(2^30 / 1000)
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 21'd1073742;

  localparam logic [WAIT_W-1:0] WAIT_MAX = 10'd1023;

  // quotient bits resolved per divider cycle
  localparam int DIV_STEPS = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAW,
    ST_CHECK,
    ST_PUSH,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic calc_raw;
    logic check;
    logic push;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic take_wait;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

[hdl/ftcs_ctrl.sv]
// sequencer for one transaction through the smoother datapath
`default_nettype none

module ftcs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ftcs_pkg::cmd_t        cmd,
  input  wire ftcs_pkg::status_t sts
);
  import ftcs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_RAW;
        end
      end
      ST_RAW: begin
        cmd.calc_raw = 1'b1;
        state_nxt    = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts.is_start || sts.take_wait) state_nxt = ST_OUT;
        else state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[hdl/ftcs_dp.sv]
// datapath: config registers, frame time, window sum, divider, output register
`default_nettype none

module ftcs_dp #(
  parameter int WINDOW = ftcs_pkg::FTCS_WINDOW
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ftcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ftcs_pkg::MIN_US_W-1:0]  cfg_data,
  input  wire logic                          in_action,
  input  wire logic [ftcs_pkg::TS_W-1:0]      in_timestamp_ms,
  output logic [ftcs_pkg::KIND_W-1:0]         out_result_kind,
  output logic [ftcs_pkg::SMOOTH_W-1:0]       out_smoothed_ms,
  output logic [ftcs_pkg::WAIT_W-1:0]         out_wait_ms,
  output logic                               out_was_capped,
  input  wire ftcs_pkg::cmd_t                 cmd,
  output ftcs_pkg::status_t                   sts
);
  import ftcs_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int HW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = SMOOTH_W + $clog2(WINDOW);
  localparam int NUM_W = SUM_W + 1;
  localparam int DVS_W = CNT_W + 1;
  localparam int REM_W = DVS_W + 1;
  localparam int ITERS = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W = ITERS * DIV_STEPS;
  localparam int ICW   = $clog2(ITERS + 1);
  localparam int PROD_W = MIN_US_W + RECIP_W;

  logic [MIN_US_W-1:0] min_us_r;
  logic [MAX_MS_W-1:0] max_ms_r;

  logic                action_r;
  logic [TS_W-1:0]     ts_r;
  logic [TS_W-1:0]     prev_r;
  logic                retry_r;
  logic [TS_W-1:0]     raw_r;
  logic [RAW_LO_W-1:0] q_r;

  logic [MAX_MS_W-1:0] cap_val_r;
  logic [KIND_W-1:0]   res_kind_r;
  logic [WAIT_W-1:0]   res_wait_r;
  logic                res_capped_r;

  logic [SMOOTH_W-1:0] hist_r [WINDOW];
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [HW-1:0]       head_r;

  logic [DIV_W-1:0]    num_r, num_nxt;
  logic [DIV_W-1:0]    quo_r, quo_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [DVS_W-1:0]    dvs_r;
  logic [ICW-1:0]      it_r;

  logic [PROD_W-1:0]   q_prod;
  logic [TS_W-1:0]     raw_nxt;
  logic                raw_hi_zero;
  logic [RAW_US_W-1:0] raw_us;
  logic                short_frame;
  logic [RAW_LO_W-1:0] wait_full;
  logic [WAIT_W-1:0]   wait_sat;
  logic                over_cap;
  logic                full;
  logic [SUM_W-1:0]    evict;
  logic [NUM_W-1:0]    num_ld;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_us_r <= MIN_FRAME_US_RST;
      max_ms_r <= MAX_FRAME_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_FRAME_US: min_us_r <= cfg_data;
        CFG_MAX_FRAME_MS: max_ms_r <= cfg_data[MAX_MS_W-1:0];
        default: ;
      endcase
    end
  end

  assign q_prod  = PROD_W'(min_us_r) * PROD_W'(RECIP_1000);
  assign raw_nxt = (ts_r < prev_r) ? TS_W'(1) : ts_r - prev_r;

  assign raw_hi_zero = (raw_r[TS_W-1:RAW_LO_W] == '0);
  assign raw_us      = RAW_US_W'(raw_r[RAW_LO_W-1:0]) * RAW_US_W'(US_PER_MS);
  assign short_frame = raw_hi_zero && (raw_us < RAW_US_W'(min_us_r));
  assign wait_full   = q_r - raw_r[RAW_LO_W-1:0];
  assign wait_sat    = wait_full[RAW_LO_W-1] ? WAIT_MAX : wait_full[WAIT_W-1:0];
  assign over_cap    = raw_r > TS_W'(max_ms_r);

  assign sts.is_start  = !action_r;
  assign sts.take_wait = !retry_r && short_frame;
  assign sts.div_done  = (it_r == ICW'(ITERS - 1));

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      action_r <= in_action;
      ts_r     <= in_timestamp_ms;
    end
    if (cmd.calc_raw) begin
      raw_r <= raw_nxt;
      q_r   <= q_prod[RECIP_SHIFT +: RAW_LO_W];
    end
  end

  // decision on the frame, reference time and retry flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      retry_r <= 1'b0;
    end else if (cmd.check) begin
      if (!action_r) begin
        prev_r  <= ts_r - START_OFFSET_MS;
        retry_r <= 1'b0;
      end else if (!retry_r && short_frame) begin
        retry_r <= 1'b1;
      end else begin
        prev_r  <= ts_r;
        retry_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      res_wait_r   <= '0;
      res_capped_r <= 1'b0;
      cap_val_r    <= over_cap ? max_ms_r : raw_r[MAX_MS_W-1:0];
      if (!action_r) begin
        res_kind_r <= KIND_START;
      end else if (!retry_r && short_frame) begin
        res_kind_r <= KIND_WAIT;
        res_wait_r <= wait_sat;
      end else begin
        res_kind_r   <= KIND_FRAME;
        res_capped_r <= over_cap;
      end
    end
  end

  // window with running sum
  assign full  = (cnt_r == CNT_W'(WINDOW));
  assign evict = full ? SUM_W'(hist_r[head_r]) : '0;

  always_ff @(posedge clk) begin
    if (cmd.push) hist_r[head_r] <= cap_val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      head_r <= '0;
    end else if (cmd.push) begin
      sum_r  <= sum_r + SUM_W'(cap_val_r) - evict;
      head_r <= (head_r == HW'(WINDOW - 1)) ? '0 : head_r + HW'(1);
      if (!full) cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // rounded mean: (2*sum + count) / (2*count), restoring division
  assign num_ld = {sum_r, 1'b0} + NUM_W'(cnt_r);

  always_comb begin
    logic [REM_W-1:0] rem_sh;
    num_nxt = num_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    for (int k = 0; k < DIV_STEPS; k++) begin
      rem_sh  = {rem_nxt[REM_W-2:0], num_nxt[DIV_W-1]};
      num_nxt = {num_nxt[DIV_W-2:0], 1'b0};
      if (rem_sh >= REM_W'(dvs_r)) begin
        rem_nxt = rem_sh - REM_W'(dvs_r);
        quo_nxt = {quo_nxt[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      num_r <= DIV_W'(num_ld);
      quo_r <= '0;
      rem_r <= '0;
      dvs_r <= {cnt_r, 1'b0};
      it_r  <= '0;
    end else if (cmd.div_step) begin
      num_r <= num_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      it_r  <= it_r + ICW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result_kind <= res_kind_r;
      out_smoothed_ms <= (res_kind_r == KIND_FRAME) ? quo_r[SMOOTH_W-1:0] : '0;
      out_wait_ms     <= res_wait_r;
      out_was_capped  <= res_capped_r;
    end
  end

endmodule

`default_nettype wire

[hdl/frame_time_clamp_smoother.sv]
// top level of the frame time clamp smoother
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | action, timestamp_ms
//  out_    | output    | out_valid/out_stall| result_kind, smoothed_ms, wait_ms, was_capped
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one transaction at a time; a start or wait item goes from accept through the
// raw and check steps to the output load, a frame item through raw, check, push,
// load and the divider, which resolves 4 quotient bits a cycle; the next input is
// accepted in the cycle after the output load
// synchronous active-low reset clears reference time, retry flag, window count,
// sum and head; config takes reset values; in_stall high and cfg_ready low in reset
// the next input is taken while a result waits under out_stall; the block holds
// its last step until the output register is free
`default_nettype none

module frame_time_clamp_smoother #(
  parameter int WINDOW = ftcs_pkg::FTCS_WINDOW
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_action,
  input  wire logic [ftcs_pkg::TS_W-1:0]       in_timestamp_ms,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [ftcs_pkg::KIND_W-1:0]          out_result_kind,
  output logic [ftcs_pkg::SMOOTH_W-1:0]        out_smoothed_ms,
  output logic [ftcs_pkg::WAIT_W-1:0]          out_wait_ms,
  output logic                                out_was_capped,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ftcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ftcs_pkg::MIN_US_W-1:0]   cfg_data
);
  import ftcs_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = rst_n;

  ftcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ftcs_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_action       (in_action),
    .in_timestamp_ms (in_timestamp_ms),
    .out_result_kind (out_result_kind),
    .out_smoothed_ms (out_smoothed_ms),
    .out_wait_ms     (out_wait_ms),
    .out_was_capped  (out_was_capped),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire
